// File: rtl/fixed_frame_sync_checksum_defines.svh
// Assertion macros used by the top level of the frame synchronizer RTL.
`ifndef FIXED_FRAME_SYNC_CHECKSUM_DEFINES_SVH
`define FIXED_FRAME_SYNC_CHECKSUM_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge out of reset.
`define FFSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame sync assertion failed");
// Next-cycle implication, checked on every rising clock edge out of reset.
`define FFSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame sync assertion failed");
`else
`define FFSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define FFSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/ffsc_pkg.sv
// Package with the types and constants of the frame synchronizer.
`timescale 1ns / 1ps
package ffsc_pkg;

    localparam int BYTE_W        = 8;
    localparam int FRAME_LEN_DEF = 32;
    localparam int CFG_IDX_W     = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_FIRST    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_SECOND   = 2'd3;

    // Register values after reset.
    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h55;
    localparam logic [BYTE_W-1:0] TAIL_FIRST_RST    = 8'h0D;
    localparam logic [BYTE_W-1:0] TAIL_SECOND_RST   = 8'h0A;

    typedef struct packed {
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
        logic [BYTE_W-1:0] tail_first;
        logic [BYTE_W-1:0] tail_second;
    } cfg_t;

    typedef struct packed {
        logic header_ok;
        logic tail_ok;
        logic sum_ok;
    } match_t;

endpackage

// File: rtl/ffsc_if.sv
// Stream interfaces for the input bytes and the emitted frame bytes.
`timescale 1ns / 1ps
interface byte_in_if;
    logic                       valid;
    logic                       ready;
    logic [ffsc_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface frame_out_if;
    logic                       valid;
    logic                       ready;
    logic [ffsc_pkg::BYTE_W-1:0] frame_byte;
    logic                       frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

// File: rtl/ffsc_cell.sv
// One byte cell of a chain: shifts in from its neighbor or loads in parallel.
`timescale 1ns / 1ps
module ffsc_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        shift_en,
    input  logic [ffsc_pkg::BYTE_W-1:0] shift_in,
    input  logic                        load_en,
    input  logic [ffsc_pkg::BYTE_W-1:0] load_in,
    output logic [ffsc_pkg::BYTE_W-1:0] q
);
    logic [ffsc_pkg::BYTE_W-1:0] q_reg;
    logic [ffsc_pkg::BYTE_W-1:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        if (load_en)
        begin
            q_next = load_in;
        end
        else if (shift_en)
        begin
            q_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;
endmodule

// File: rtl/ffsc_window.sv
// Sliding byte window built from a chain of cells, with a running body checksum.
`timescale 1ns / 1ps
module ffsc_window #(
    parameter int FRAME_LEN = ffsc_pkg::FRAME_LEN_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        shift_en,
    input  logic [ffsc_pkg::BYTE_W-1:0]                 in_byte,
    input  ffsc_pkg::cfg_t                              cfg,
    output logic [FRAME_LEN-1:0][ffsc_pkg::BYTE_W-1:0]  win_next,
    output ffsc_pkg::match_t                            match
);
    logic [FRAME_LEN-1:0][ffsc_pkg::BYTE_W-1:0] win;
    logic [ffsc_pkg::BYTE_W-1:0]                sum_reg;
    logic [ffsc_pkg::BYTE_W-1:0]                sum_next;

    genvar k;
    generate
        for (k = 0; k < FRAME_LEN; k++)
        begin : g_cell
            if (k == FRAME_LEN - 1)
            begin : g_tail
                assign win_next[k] = in_byte;
            end
            else
            begin : g_body
                assign win_next[k] = win[k+1];
            end

            ffsc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .shift_in (win_next[k]),
                .load_en  (1'b0),
                .load_in  (win_next[k]),
                .q        (win[k])
            );
        end
    endgenerate

    // The body moves up by one byte: the old byte 2 leaves it and the old
    // checksum slot (byte LEN-3) becomes its last byte.
    assign sum_next = sum_reg - win[2] + win[FRAME_LEN-3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (shift_en)
        begin
            sum_reg <= sum_next;
        end
    end

    always_comb
    begin
        match.header_ok = (win_next[0] == cfg.header_first) &&
                          (win_next[1] == cfg.header_second);
        match.tail_ok   = (win_next[FRAME_LEN-2] == cfg.tail_first) &&
                          (win_next[FRAME_LEN-1] == cfg.tail_second);
        match.sum_ok    = (win_next[FRAME_LEN-3] == sum_next);
    end
endmodule

// File: rtl/ffsc_frame_buf.sv
// Output chain of cells that holds one validated frame and shifts it out.
`timescale 1ns / 1ps
module ffsc_frame_buf #(
    parameter int FRAME_LEN = ffsc_pkg::FRAME_LEN_DEF,
    localparam int CNT_W    = $clog2(FRAME_LEN + 1)
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        load_en,
    input  logic [FRAME_LEN-1:0][ffsc_pkg::BYTE_W-1:0]  load_bytes,
    input  logic                                        pop,
    output logic [CNT_W-1:0]                            count,
    output logic [ffsc_pkg::BYTE_W-1:0]                 head_byte
);
    logic [FRAME_LEN-1:0][ffsc_pkg::BYTE_W-1:0] q;
    logic [FRAME_LEN-1:0][ffsc_pkg::BYTE_W-1:0] shift_src;
    logic [CNT_W-1:0]                            count_reg;
    logic [CNT_W-1:0]                            count_next;

    genvar k;
    generate
        for (k = 0; k < FRAME_LEN; k++)
        begin : g_cell
            if (k == FRAME_LEN - 1)
            begin : g_end
                assign shift_src[k] = '0;
            end
            else
            begin : g_mid
                assign shift_src[k] = q[k+1];
            end

            ffsc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (pop),
                .shift_in (shift_src[k]),
                .load_en  (load_en),
                .load_in  (load_bytes[k]),
                .q        (q[k])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (load_en)
        begin
            count_next = CNT_W'(FRAME_LEN);
        end
        else if (pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count     = count_reg;
    assign head_byte = q[0];
endmodule

// File: rtl/fixed_frame_sync_checksum.sv
// Top level of the fixed-length frame synchronizer with additive checksum.
//
//   Channel  Dir  Payload                    Beat
//   rx       in   in_byte[7:0]               one received byte
//   tx       out  frame_byte[7:0], last      one byte of a validated frame
//   cfg      in   cfg_idx[1:0], cfg_data     one register write, no wait
//
// Every input byte shifts the window and is checked in the cycle it is
// accepted, so one byte per cycle is sustained. A matching frame is copied
// in parallel into the output chain and leaves at one beat per cycle while
// tx is ready, FRAME_LEN beats per frame. The input stalls only when the
// incoming byte could complete a frame while the output chain still holds
// more than a last beat that leaves in the same cycle. Reset clears the
// window, the checksum, the freshness count and the output chain at once.
`timescale 1ns / 1ps
`include "fixed_frame_sync_checksum_defines.svh"
module fixed_frame_sync_checksum #(
    parameter int FRAME_LEN = ffsc_pkg::FRAME_LEN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    byte_in_if.sink                        rx,
    frame_out_if.source                    tx,
    input  logic                           cfg_we,
    input  logic [ffsc_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [ffsc_pkg::BYTE_W-1:0]    cfg_data
);
    localparam int FC_W  = $clog2(FRAME_LEN);
    localparam int CNT_W = $clog2(FRAME_LEN + 1);

    ffsc_pkg::cfg_t cfg_reg;
    ffsc_pkg::cfg_t cfg_next;

    // Count of window bytes, the incoming one excluded, that belong to no
    // emitted frame. It saturates at FRAME_LEN-1.
    logic [FC_W-1:0] fresh_reg;
    logic [FC_W-1:0] fresh_next;

    logic [FRAME_LEN-1:0][ffsc_pkg::BYTE_W-1:0] win_next;
    ffsc_pkg::match_t                            match;
    logic [CNT_W-1:0]                            buf_count;
    logic                                        full_fresh;
    logic                                        rx_fire;
    logic                                        tx_fire;
    logic                                        emit;

    // Register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                ffsc_pkg::REG_HEADER_FIRST:  cfg_next.header_first  = cfg_data;
                ffsc_pkg::REG_HEADER_SECOND: cfg_next.header_second = cfg_data;
                ffsc_pkg::REG_TAIL_FIRST:    cfg_next.tail_first    = cfg_data;
                ffsc_pkg::REG_TAIL_SECOND:   cfg_next.tail_second   = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first  <= ffsc_pkg::HEADER_FIRST_RST;
            cfg_reg.header_second <= ffsc_pkg::HEADER_SECOND_RST;
            cfg_reg.tail_first    <= ffsc_pkg::TAIL_FIRST_RST;
            cfg_reg.tail_second   <= ffsc_pkg::TAIL_SECOND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Only a byte that finds the window fully fresh can complete a frame,
    // so only then does the input wait for room in the output chain.
    assign full_fresh = (fresh_reg == FC_W'(FRAME_LEN - 1));
    assign rx.ready   = !full_fresh || (buf_count == '0) ||
                        ((buf_count == CNT_W'(1)) && tx.ready);
    assign rx_fire    = rx.valid && rx.ready;
    assign tx_fire    = tx.valid && tx.ready;
    assign emit       = rx_fire && full_fresh &&
                        match.header_ok && match.tail_ok && match.sum_ok;

    always_comb
    begin
        fresh_next = fresh_reg;
        if (emit)
        begin
            fresh_next = '0;
        end
        else if (rx_fire && !full_fresh)
        begin
            fresh_next = fresh_reg + FC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg <= '0;
        end
        else
        begin
            fresh_reg <= fresh_next;
        end
    end

    ffsc_window #(
        .FRAME_LEN (FRAME_LEN)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (rx_fire),
        .in_byte  (rx.in_byte),
        .cfg      (cfg_reg),
        .win_next (win_next),
        .match    (match)
    );

    ffsc_frame_buf #(
        .FRAME_LEN (FRAME_LEN)
    ) u_frame_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_en    (emit),
        .load_bytes (win_next),
        .pop        (tx_fire),
        .count      (buf_count),
        .head_byte  (tx.frame_byte)
    );

    assign tx.valid      = (buf_count != '0);
    assign tx.frame_last = (buf_count == CNT_W'(1));

    // A frame is only loaded when the output chain is empty or is handing
    // over its last beat in the same cycle.
    `FFSC_ASSERT_IMPLY(a_load_room, clk, rst_n, emit, (!tx.valid || (tx_fire && tx.frame_last)))
    // A loaded frame is presented in full on the next cycle.
    `FFSC_ASSERT_NEXT(a_load_full, clk, rst_n, emit, buf_count == CNT_W'(FRAME_LEN))
    // Emitting a frame retires every byte of the window.
    `FFSC_ASSERT_NEXT(a_fresh_restart, clk, rst_n, emit, fresh_reg == '0)
    // The beat count only drops by one for a delivered beat without a load.
    `FFSC_ASSERT_NEXT(a_pop, clk, rst_n, tx_fire && !emit, buf_count == $past(buf_count) - CNT_W'(1))
endmodule
